/* src/mask_keyspace_counter_macros.svh */
// ----------------------------------------------------------------------------
// mask_keyspace_counter_macros.svh
// Assertion macros used by the checker file of the keyspace counter.
// ----------------------------------------------------------------------------
`ifndef MASK_KEYSPACE_COUNTER_MACROS_SVH
`define MASK_KEYSPACE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MKC_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MKC_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* src/mkc_pkg.sv */
// ----------------------------------------------------------------------------
// mkc_pkg
// Widths, codes and the class-size decode of the mask keyspace counter.
// ----------------------------------------------------------------------------
package mkc_pkg;

  localparam int unsigned PROD_W = 60;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned NDIG   = PROD_W / DIG_W;
  localparam int unsigned CNT_W  = $clog2(NDIG);
  localparam int unsigned T_W    = SIZE_W + DIG_W;
  localparam int unsigned NCUST  = 4;
  localparam int unsigned IDX_W  = $clog2(NCUST);

  localparam logic [PROD_W-1:0] KEYSPACE_CAP = 60'd1000000000000000000;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_CAP  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // Mask characters
  localparam logic [7:0] CH_ESC = 8'h3F;  // '?'
  localparam logic [7:0] CH_LOW = 8'h6C;  // 'l'
  localparam logic [7:0] CH_UP  = 8'h75;  // 'u'
  localparam logic [7:0] CH_DIG = 8'h64;  // 'd'
  localparam logic [7:0] CH_SPC = 8'h73;  // 's'
  localparam logic [7:0] CH_ALL = 8'h61;  // 'a'
  localparam logic [7:0] CH_BYT = 8'h62;  // 'b'
  localparam logic [7:0] CH_HXL = 8'h68;  // 'h'
  localparam logic [7:0] CH_HXU = 8'h48;  // 'H'
  localparam logic [7:0] CH_C1  = 8'h31;  // '1'
  localparam logic [7:0] CH_C2  = 8'h32;
  localparam logic [7:0] CH_C3  = 8'h33;
  localparam logic [7:0] CH_C4  = 8'h34;

  // Built-in class sizes
  localparam logic [SIZE_W-1:0] SZ_ALPHA = 16'd26;
  localparam logic [SIZE_W-1:0] SZ_DIGIT = 16'd10;
  localparam logic [SIZE_W-1:0] SZ_SPEC  = 16'd33;
  localparam logic [SIZE_W-1:0] SZ_PRINT = 16'd95;
  localparam logic [SIZE_W-1:0] SZ_BYTE  = 16'd256;
  localparam logic [SIZE_W-1:0] SZ_HEX   = 16'd16;
  localparam logic [SIZE_W-1:0] SZ_ONE   = 16'd1;

  // Request into the digit-serial multiplier
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] size;
  } mkc_mul_req_t;

  // Response from the digit-serial multiplier
  typedef struct packed {
    logic done;
    logic over;
  } mkc_mul_rsp_t;

  // Size named by the byte after '?'; cust holds set four down to set one
  function automatic logic [SIZE_W-1:0] esc_size(input logic [7:0] c,
                                                 input logic [NCUST*SIZE_W-1:0] cust);
    logic [SIZE_W-1:0] s;
    case (c)
      CH_LOW, CH_UP:  s = SZ_ALPHA;
      CH_DIG:         s = SZ_DIGIT;
      CH_SPC:         s = SZ_SPEC;
      CH_ALL:         s = SZ_PRINT;
      CH_BYT:         s = SZ_BYTE;
      CH_HXL, CH_HXU: s = SZ_HEX;
      CH_C1:          s = cust[0*SIZE_W +: SIZE_W];
      CH_C2:          s = cust[1*SIZE_W +: SIZE_W];
      CH_C3:          s = cust[2*SIZE_W +: SIZE_W];
      CH_C4:          s = cust[3*SIZE_W +: SIZE_W];
      default:        s = SZ_ONE;
    endcase
    return s;
  endfunction

endpackage

/* src/mask_keyspace_counter.sv */
// ----------------------------------------------------------------------------
// mask_keyspace_counter
// Parses a password mask byte by byte and multiplies the candidate counts
// of its positions, reporting the keyspace and a status on the last byte.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid/in_ready, mask_char, is_last | input
//  out     | out_valid/out_ready, keyspace, status | output
//  cfg     | cfg_valid/cfg_ready, index, data      | input
//
//  A byte that does not close a class token needs no multiply.
//  A byte that closes a class of size above one, with no error set, starts
//  the multiplier, which steps through the 15 four-bit digits of the product.
//  After the last byte the result register is loaded in ST_OUT; bytes of the
//  next mask are taken while that result waits on out_ready.
//  Synchronous active-low reset clears the product to one; cfg always ready.
// ----------------------------------------------------------------------------
module mask_keyspace_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_mask_char,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mkc_pkg::PROD_W-1:0]  out_keyspace,
  output logic [1:0]                  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mkc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mkc_pkg::SIZE_W-1:0]  cfg_data
);
  import mkc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state_r;
  logic [SIZE_W-1:0] cust_r [NCUST];
  logic [PROD_W-1:0] prod_r;
  logic [1:0]        err_r;
  logic              esc_r;
  logic              last_r;
  logic              out_valid_r;
  logic [PROD_W-1:0] out_keyspace_r;
  logic [1:0]        out_status_r;

  logic              in_acc;
  logic              out_load;
  logic [SIZE_W-1:0] size;
  logic              need_mul;
  mkc_mul_req_t      mul_req;
  mkc_mul_rsp_t      mul_rsp;
  logic [PROD_W-1:0] mul_prod;

  // Decode of the current byte
  always_comb begin
    in_acc   = in_valid && in_ready;
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
    size     = esc_size(in_mask_char, {cust_r[3], cust_r[2], cust_r[1], cust_r[0]});
    need_mul = esc_r && (err_r == STAT_OK) && (size > SZ_ONE);
    mul_req.start = in_acc && need_mul;
    mul_req.size  = size;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  mkc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (mul_req),
    .mcand_i (prod_r),
    .rsp_o   (mul_rsp),
    .prod_o  (mul_prod)
  );

  // Custom set sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCUST; i++) begin
        cust_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      cust_r[cfg_index] <= cfg_data;
    end
  end

  // Parser and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prod_r      <= PROD_W'(1);
      err_r       <= STAT_OK;
      esc_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            last_r <= in_is_last;
            if (esc_r) begin
              esc_r <= 1'b0;
              if (err_r == STAT_OK && size == '0) begin
                err_r <= STAT_ZERO;
              end
            end else if (in_mask_char == CH_ESC && !in_is_last) begin
              esc_r <= 1'b1;
            end
            if (need_mul) begin
              state_r <= ST_MUL;
            end else if (in_is_last) begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            if (mul_rsp.over) begin
              err_r <= STAT_CAP;
            end else begin
              prod_r <= mul_prod;
            end
            state_r <= last_r ? ST_OUT : ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            prod_r      <= PROD_W'(1);
            err_r       <= STAT_OK;
            esc_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_keyspace_r <= (err_r == STAT_OK) ? prod_r : '0;
      out_status_r   <= err_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_keyspace = out_keyspace_r;
  assign out_status   = out_status_r;

endmodule

/* src/mkc_mul.sv */
// ----------------------------------------------------------------------------
// mkc_mul
// Digit-serial multiply of the running product by a 16-bit size, with a
// serial compare of the product against the keyspace cap.
// ----------------------------------------------------------------------------
module mkc_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mkc_pkg::mkc_mul_req_t       req_i,
  input  logic [mkc_pkg::PROD_W-1:0]  mcand_i,
  output mkc_pkg::mkc_mul_rsp_t       rsp_o,
  output logic [mkc_pkg::PROD_W-1:0]  prod_o
);
  import mkc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] a_r;
  logic [PROD_W-1:0] res_r;
  logic [PROD_W-1:0] res_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] carry_r;
  logic [SIZE_W-1:0] carry_nxt;
  logic              gt_r;
  logic              gt_nxt;
  logic [DIG_W-1:0]  dig;
  logic [DIG_W-1:0]  cap_dig;
  logic [T_W-1:0]    t;

  // One digit step: digit times size plus carry
  always_comb begin
    dig       = a_r[DIG_W-1:0];
    cap_dig   = KEYSPACE_CAP[int'(cnt_r)*DIG_W +: DIG_W];
    t         = T_W'(dig) * T_W'(size_r) + T_W'(carry_r);
    res_nxt   = {t[DIG_W-1:0], res_r[PROD_W-1:DIG_W]};
    carry_nxt = t[T_W-1:DIG_W];
    // LSB-first compare: a higher digit overrides the verdict so far
    if (t[DIG_W-1:0] > cap_dig) begin
      gt_nxt = 1'b1;
    end else if (t[DIG_W-1:0] < cap_dig) begin
      gt_nxt = 1'b0;
    end else begin
      gt_nxt = gt_r;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NDIG - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      a_r     <= mcand_i;
      size_r  <= req_i.size;
      carry_r <= '0;
      gt_r    <= 1'b0;
    end else if (busy_r) begin
      a_r     <= a_r >> DIG_W;
      res_r   <= res_nxt;
      carry_r <= carry_nxt;
      gt_r    <= gt_nxt;
    end
  end

  // Cap bits 60 and up are zero, so any carry out is over the cap
  assign rsp_o.done = done_r;
  assign rsp_o.over = (carry_r != '0) || gt_r;
  assign prod_o     = res_r;

endmodule

/* src/mkc_chk.sv */
// ----------------------------------------------------------------------------
// mkc_chk
// Port-level checks of the mask keyspace counter's result channel.
// ----------------------------------------------------------------------------
`include "mask_keyspace_counter_macros.svh"

module mkc_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mkc_pkg::PROD_W-1:0]  out_keyspace,
  input logic [1:0]                  out_status
);
  import mkc_pkg::*;

  // A stalled result transaction stays offered
  `MKC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Status three is never produced
  `MKC_ASSERT_NOW(a_status_code, out_valid, out_status != 2'd3, "undefined status code")

  // An error result carries a zero keyspace
  `MKC_ASSERT_NOW(a_err_zero, out_valid && out_status != STAT_OK, out_keyspace == '0, "error result with nonzero keyspace")

  // A good result is nonzero and within the cap
  `MKC_ASSERT_NOW(a_ok_range, out_valid && out_status == STAT_OK, out_keyspace != '0 && out_keyspace <= KEYSPACE_CAP, "keyspace out of range")

endmodule

bind mask_keyspace_counter mkc_chk u_mkc_chk (.*);
